>>> hdl/calo_cell_binning_accumulate_macros.svh
// Assertion macros for the calorimeter cell binning block.
// Included by the top level; depends on nothing else.
`ifndef CALO_CELL_BINNING_ACCUMULATE_MACROS_SVH
`define CALO_CELL_BINNING_ACCUMULATE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBCA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBCA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/cbca_pkg.sv
// Shared types, constants and helper functions for the cell binning block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cbca_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_ETA_MAX        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSITION_ETA = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_IN_ETA   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_IN_PHI   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ETA_SCALE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PHI_SCALE      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ETA_WIDTH      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PHI_WIDTH      = 3'd7;

	localparam logic [1:0] DROP_NONE    = 2'd0;
	localparam logic [1:0] DROP_OUTSIDE = 2'd1;
	localparam logic [1:0] DROP_FULL    = 2'd2;

	localparam logic [15:0] PI_Q12   = 16'd12868;
	localparam logic [23:0] PT_MAX   = 24'hFFFFFF;
	localparam logic [15:0] HITS_MAX = 16'hFFFF;

	typedef struct packed {
		logic [14:0] eta_max;
		logic [14:0] transition_eta;
		logic [11:0] cells_in_phi;
		logic [23:0] eta_scale;
		logic [23:0] phi_scale;
		logic [19:0] eta_width;
		logic [19:0] phi_width;
	} cbca_cfg_t;

	typedef struct packed {
		logic capture;
		logic clear;
		logic outside;
		logic init_search;
		logic search;
		logic hit_upd;
		logic miss_upd;
	} cbca_cmd_t;

	typedef struct packed {
		logic in_clear;
		logic in_outside;
		logic hit;
		logic exhausted;
	} cbca_stat_t;

	typedef struct packed {
		logic [23:0]        cell_id;
		logic [23:0]        pt_sum;
		logic [15:0]        hits;
		logic signed [15:0] ceta;
		logic signed [15:0] cphi;
	} cbca_entry_t;

	// Rounds a 2^-21 product to Q3.12, subtracts the offset and saturates.
	function automatic logic signed [15:0] sat_centre(input logic [37:0] u,
			input logic [15:0] base);
		logic [38:0]        r;
		logic signed [31:0] q;
		r = {1'b0, u} + 39'd256;
		q = $signed({2'b00, r[38:9]}) - $signed({16'h0000, base});
		if (q > 32'sd32767) begin
			sat_centre = 16'sh7FFF;
		end else if (q < -32'sd32768) begin
			sat_centre = 16'sh8000;
		end else begin
			sat_centre = q[15:0];
		end
	endfunction

endpackage

>>> hdl/cbca_cfg.sv
// Configuration register file of the cell binning block.
// Depends on cbca_pkg for register indexes and the configuration struct.
`timescale 1ns / 1ps

module cbca_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [cbca_pkg::CFG_IDX_W-1:0]  idx,
	input  logic [cbca_pkg::CFG_DATA_W-1:0] data,
	output cbca_pkg::cbca_cfg_t            cfg
);
	import cbca_pkg::*;

	cbca_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eta_max        <= 15'd20480;
			cfg_q.transition_eta <= 15'd13107;
			cfg_q.cells_in_phi   <= 12'd640;
			cfg_q.eta_scale      <= 24'd409600;
			cfg_q.phi_scale      <= 24'd417222;
			cfg_q.eta_width      <= 20'd10486;
			cfg_q.phi_width      <= 20'd10294;
		end else if (we) begin
			case (idx)
				REG_ETA_MAX:        cfg_q.eta_max        <= data[14:0];
				REG_TRANSITION_ETA: cfg_q.transition_eta <= data[14:0];
				REG_CELLS_IN_ETA:   ;
				REG_CELLS_IN_PHI:   cfg_q.cells_in_phi   <= data[11:0];
				REG_ETA_SCALE:      cfg_q.eta_scale      <= data[23:0];
				REG_PHI_SCALE:      cfg_q.phi_scale      <= data[23:0];
				REG_ETA_WIDTH:      cfg_q.eta_width      <= data[19:0];
				REG_PHI_WIDTH:      cfg_q.phi_width      <= data[19:0];
				default:            ;
			endcase
		end
	end

	// The fine eta bin count is carried by the eta scale, so it is not stored.
	assign cfg = cfg_q;

endmodule

>>> hdl/cbca_ctrl.sv
// Controller state machine of the cell binning block.
// Depends on cbca_pkg for the command and status structs.
`timescale 1ns / 1ps

module cbca_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output cbca_pkg::cbca_cmd_t   cmd,
	input  cbca_pkg::cbca_stat_t  stat
);
	import cbca_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CALC1  = 3'd1;
	localparam logic [2:0] ST_CALC2  = 3'd2;
	localparam logic [2:0] ST_CALC3  = 3'd3;
	localparam logic [2:0] ST_SEARCH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (stat.in_clear) begin
						cmd.clear = 1'b1;
					end else if (stat.in_outside) begin
						cmd.outside = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						state_d     = ST_CALC1;
					end
				end
			end
			ST_CALC1: state_d = ST_CALC2;
			ST_CALC2: state_d = ST_CALC3;
			ST_CALC3: begin
				cmd.init_search = 1'b1;
				state_d         = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (stat.hit) begin
					cmd.hit_upd = 1'b1;
					state_d     = ST_IDLE;
				end else if (stat.exhausted) begin
					cmd.miss_upd = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					cmd.search = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

>>> hdl/cbca_dp.sv
// Datapath of the cell binning block: binning arithmetic, cell store and results.
// Depends on cbca_pkg; driven by the commands of cbca_ctrl.
`timescale 1ns / 1ps

module cbca_dp #(
	parameter int MAX_CELLS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cbca_pkg::cbca_cfg_t   cfg,
	input  cbca_pkg::cbca_cmd_t   cmd,
	output cbca_pkg::cbca_stat_t  stat,
	input  logic                  mode,
	input  logic [19:0]           deposit_pt,
	input  logic signed [15:0]    deposit_eta,
	input  logic signed [15:0]    deposit_phi,
	output logic                  done,
	output logic [23:0]           cell_id,
	output logic [7:0]            slot,
	output logic                  new_cell,
	output logic [23:0]           cell_pt_sum,
	output logic [15:0]           cell_hit_count,
	output logic signed [15:0]    centre_eta,
	output logic signed [15:0]    centre_phi,
	output logic [1:0]            dropped
);
	import cbca_pkg::*;

	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int CW = $clog2(MAX_CELLS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CELLS);

	// Input decode.
	logic signed [16:0] eta_x;
	logic [16:0]        aeta_x;
	logic signed [16:0] eta_sum_x;
	logic signed [17:0] phi_sum_x;
	logic [15:0]        phi_off_x;
	logic               fine_x;

	assign eta_x     = {deposit_eta[15], deposit_eta};
	assign aeta_x    = eta_x[16] ? 17'(-eta_x) : 17'(eta_x);
	assign eta_sum_x = eta_x + $signed({2'b00, cfg.eta_max});
	assign phi_sum_x = {{2{deposit_phi[15]}}, deposit_phi} + $signed({2'b00, PI_Q12});
	assign phi_off_x = phi_sum_x[17] ? 16'd0 : phi_sum_x[15:0];
	assign fine_x    = aeta_x < {2'b00, cfg.transition_eta};

	assign stat.in_clear   = mode;
	assign stat.in_outside = aeta_x > {2'b00, cfg.eta_max};

	logic [15:0] eta_off_q;
	logic [15:0] phi_off_q;
	logic        fine_q;
	logic [19:0] pt_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			eta_off_q <= eta_sum_x[15:0];
			phi_off_q <= phi_off_x;
			fine_q    <= fine_x;
			pt_q      <= deposit_pt;
		end
	end

	// Stage 1: scale the offsets into bin units.
	logic [39:0] peta_s1;
	logic [39:0] pphi_s1;
	logic        fine_s1;

	always_ff @(posedge clk) begin
		peta_s1 <= eta_off_q * cfg.eta_scale;
		pphi_s1 <= phi_off_q * cfg.phi_scale;
		fine_s1 <= fine_q;
	end

	// Stage 2: bin indexes, centre products and the eta part of the id.
	logic [16:0] ieta_x;
	logic [16:0] iphi_x;
	logic [17:0] meta_x;
	logic [17:0] mphi_x;

	assign ieta_x = fine_s1 ? (17'(peta_s1[39:24]) + 17'd1) : {1'b0, peta_s1[39:25], 1'b1};
	assign iphi_x = fine_s1 ? (17'(pphi_s1[39:24]) + 17'd1) : {1'b0, pphi_s1[39:25], 1'b1};
	assign meta_x = fine_s1 ? ({ieta_x, 1'b0} - 18'd1) : {ieta_x, 1'b0};
	assign mphi_x = fine_s1 ? ({iphi_x, 1'b0} - 18'd1) : {iphi_x, 1'b0};

	logic [37:0] ueta_s2;
	logic [37:0] uphi_s2;
	logic [28:0] idp_s2;
	logic [16:0] iphi_s2;

	always_ff @(posedge clk) begin
		ueta_s2 <= meta_x * cfg.eta_width;
		uphi_s2 <= mphi_x * cfg.phi_width;
		idp_s2  <= ieta_x * cfg.cells_in_phi;
		iphi_s2 <= iphi_x;
	end

	// Stage 3: cell id and rounded, saturated centres.
	logic [28:0]        id_sum_x;
	logic [23:0]        id_s3;
	logic signed [15:0] ceta_s3;
	logic signed [15:0] cphi_s3;

	assign id_sum_x = idp_s2 + {12'd0, iphi_s2};

	always_ff @(posedge clk) begin
		id_s3   <= id_sum_x[23:0];
		ceta_s3 <= sat_centre(ueta_s2, {1'b0, cfg.eta_max});
		cphi_s3 <= sat_centre(uphi_s2, PI_Q12);
	end

	// Cell store and linear search, one entry compared per cycle.
	cbca_entry_t mem [MAX_CELLS];
	cbca_entry_t rdata_q;
	cbca_entry_t wdata_x;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] used_q;
	logic          rd_vld_q;
	logic          rd_go;
	logic          full;
	logic          mem_we;
	logic [AW-1:0] waddr_x;

	assign full           = (used_q >= MAX_CNT);
	assign rd_go          = cmd.search && (ptr_q < used_q);
	assign stat.hit       = rd_vld_q && (rdata_q.cell_id == id_s3);
	assign stat.exhausted = !rd_vld_q && (ptr_q >= used_q);

	logic [24:0] sum_x;
	logic [23:0] sum_sat_x;
	logic [15:0] hits_x;

	assign sum_x     = {1'b0, rdata_q.pt_sum} + {5'd0, pt_q};
	assign sum_sat_x = sum_x[24] ? PT_MAX : sum_x[23:0];
	assign hits_x    = (rdata_q.hits == HITS_MAX) ? HITS_MAX : (rdata_q.hits + 16'd1);

	always_comb begin
		if (cmd.hit_upd) begin
			wdata_x.cell_id = rdata_q.cell_id;
			wdata_x.pt_sum  = sum_sat_x;
			wdata_x.hits    = hits_x;
			wdata_x.ceta    = rdata_q.ceta;
			wdata_x.cphi    = rdata_q.cphi;
		end else begin
			wdata_x.cell_id = id_s3;
			wdata_x.pt_sum  = {4'd0, pt_q};
			wdata_x.hits    = 16'd1;
			wdata_x.ceta    = ceta_s3;
			wdata_x.cphi    = cphi_s3;
		end
	end

	assign mem_we  = cmd.hit_upd || (cmd.miss_upd && !full);
	assign waddr_x = cmd.hit_upd ? rd_idx_q[AW-1:0] : used_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr_x] <= wdata_x;
		end
		if (rd_go) begin
			rdata_q  <= mem[ptr_q[AW-1:0]];
			rd_idx_q <= ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			rd_vld_q <= 1'b0;
			used_q   <= '0;
		end else begin
			if (cmd.init_search) begin
				ptr_q    <= '0;
				rd_vld_q <= 1'b0;
			end else if (cmd.search) begin
				rd_vld_q <= rd_go;
				if (rd_go) begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
			if (cmd.clear) begin
				used_q <= '0;
			end else if (cmd.miss_upd && !full) begin
				used_q <= used_q + CW'(1);
			end
		end
	end

	// Result registers.
	logic [CW+7:0] hit_ext_x;
	logic [CW+7:0] new_ext_x;

	assign hit_ext_x = {8'd0, rd_idx_q};
	assign new_ext_x = {8'd0, used_q};

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.clear || cmd.outside || cmd.hit_upd || cmd.miss_upd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear || cmd.outside) begin
			cell_id        <= '0;
			slot           <= '0;
			new_cell       <= 1'b0;
			cell_pt_sum    <= '0;
			cell_hit_count <= '0;
			centre_eta     <= '0;
			centre_phi     <= '0;
			dropped        <= cmd.outside ? DROP_OUTSIDE : DROP_NONE;
		end else if (cmd.hit_upd) begin
			cell_id        <= id_s3;
			slot           <= hit_ext_x[7:0];
			new_cell       <= 1'b0;
			cell_pt_sum    <= sum_sat_x;
			cell_hit_count <= hits_x;
			centre_eta     <= rdata_q.ceta;
			centre_phi     <= rdata_q.cphi;
			dropped        <= DROP_NONE;
		end else if (cmd.miss_upd) begin
			cell_id    <= id_s3;
			centre_eta <= ceta_s3;
			centre_phi <= cphi_s3;
			if (full) begin
				slot           <= '0;
				new_cell       <= 1'b0;
				cell_pt_sum    <= '0;
				cell_hit_count <= '0;
				dropped        <= DROP_FULL;
			end else begin
				slot           <= new_ext_x[7:0];
				new_cell       <= 1'b1;
				cell_pt_sum    <= {4'd0, pt_q};
				cell_hit_count <= 16'd1;
				dropped        <= DROP_NONE;
			end
		end
	end

	assign done = done_q;

endmodule

>>> hdl/calo_cell_binning_accumulate.sv
// A clear or an out-of-acceptance deposit gives its result in the cycle after start.
// A deposit first passes the binning arithmetic (scaling, bin indexes, cell id and centres),
// then a linear search of the cell store that compares one entry per cycle through its port.
// A new transfer may start in the cycle that busy falls; the result strobe cannot be held off.
// Reset clears the store fill count and loads the default configuration; store contents
// are left as they are, since only entries below the fill count are ever read.
`timescale 1ns / 1ps
`include "calo_cell_binning_accumulate_macros.svh"

module calo_cell_binning_accumulate #(
	parameter int MAX_CELLS = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           mode,
	input  logic [19:0]                    deposit_pt,
	input  logic signed [15:0]             deposit_eta,
	input  logic signed [15:0]             deposit_phi,
	input  logic                           cfg_we,
	input  logic [cbca_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbca_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           done,
	output logic [23:0]                    cell_id,
	output logic [7:0]                     slot,
	output logic                           new_cell,
	output logic [23:0]                    cell_pt_sum,
	output logic [15:0]                    cell_hit_count,
	output logic signed [15:0]             centre_eta,
	output logic signed [15:0]             centre_phi,
	output logic [1:0]                     dropped
);
	import cbca_pkg::*;

	cbca_cfg_t  cfg;
	cbca_cmd_t  cmd;
	cbca_stat_t stat;
	logic       start_ok;

	assign start_ok = start && !busy;

	cbca_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	cbca_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	cbca_dp #(
		.MAX_CELLS (MAX_CELLS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.stat           (stat),
		.mode           (mode),
		.deposit_pt     (deposit_pt),
		.deposit_eta    (deposit_eta),
		.deposit_phi    (deposit_phi),
		.done           (done),
		.cell_id        (cell_id),
		.slot           (slot),
		.new_cell       (new_cell),
		.cell_pt_sum    (cell_pt_sum),
		.cell_hit_count (cell_hit_count),
		.centre_eta     (centre_eta),
		.centre_phi     (centre_phi),
		.dropped        (dropped)
	);

	`CBCA_ASSERT_NXT(a_clear_result, clk, arst_n, start_ok && mode, done && cell_id == 24'd0 && dropped == DROP_NONE && !busy, "clear did not give a zero result in the next cycle")
	`CBCA_ASSERT_IMP(a_new_cell_first_hit, clk, arst_n, done && new_cell, cell_hit_count == 16'd1 && dropped == DROP_NONE, "new cell result without a single hit")
	`CBCA_ASSERT_IMP(a_full_no_entry, clk, arst_n, done && dropped == DROP_FULL, !new_cell && slot == 8'd0 && cell_pt_sum == 24'd0, "store full result carries entry data")

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for calo_cell_binning_accumulate: directed and random deposits and
// clears under several register settings, checked against an in-bench binning and store model.
// Depends on cbca_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
	import cbca_pkg::*;

	localparam int STORE_DEPTH = 256;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 300;
	localparam int REPORT_CAP = 60;
	localparam logic [19:0] DEPOSIT_PT_MAX = 20'hFFFFF;

	typedef struct packed {
		logic [14:0] eta_max;
		logic [14:0] transition_eta;
		logic [11:0] cells_in_eta;
		logic [11:0] cells_in_phi;
		logic [23:0] eta_scale;
		logic [23:0] phi_scale;
		logic [19:0] eta_width;
		logic [19:0] phi_width;
	} binning_cfg_t;

	localparam binning_cfg_t DEFAULT_CFG = '{15'd20480, 15'd13107, 12'd1000, 12'd640,
		24'd409600, 24'd417222, 20'd10486, 20'd10294};

	typedef struct {
		bit                 is_reg;
		logic [2:0]         reg_idx;
		logic [23:0]        reg_val;
		logic               mode;
		logic [19:0]        pt;
		logic signed [15:0] eta;
		logic signed [15:0] phi;
		int                 gap;
	} stim_t;

	typedef struct packed {
		logic [23:0] cell_id;
		logic [7:0]  slot;
		logic        new_cell;
		logic [23:0] pt_sum;
		logic [15:0] hits;
		logic [15:0] ceta;
		logic [15:0] cphi;
		logic [1:0]  dropped;
	} cell_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic mode = 1'b0;
	logic [19:0] deposit_pt = '0;
	logic signed [15:0] deposit_eta = '0;
	logic signed [15:0] deposit_phi = '0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic busy;
	logic done;
	logic [23:0] cell_id;
	logic [7:0] slot;
	logic new_cell;
	logic [23:0] cell_pt_sum;
	logic [15:0] cell_hit_count;
	logic signed [15:0] centre_eta;
	logic signed [15:0] centre_phi;
	logic [1:0] dropped;

	calo_cell_binning_accumulate uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.deposit_pt(deposit_pt), .deposit_eta(deposit_eta), .deposit_phi(deposit_phi),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
		.cell_id(cell_id), .slot(slot), .new_cell(new_cell), .cell_pt_sum(cell_pt_sum),
		.cell_hit_count(cell_hit_count), .centre_eta(centre_eta), .centre_phi(centre_phi),
		.dropped(dropped)
	);

	stim_t pending[$];
	cell_result_t expected_cells[$];

	binning_cfg_t cfg_m = DEFAULT_CFG;
	logic [23:0] store_id[STORE_DEPTH];
	logic [23:0] store_pt[STORE_DEPTH];
	logic [15:0] store_hits[STORE_DEPTH];
	logic [15:0] store_ceta[STORE_DEPTH];
	logic [15:0] store_cphi[STORE_DEPTH];
	int fill_count = 0;

	int n_transfers = 0, n_clears = 0, n_new = 0, n_hits = 0, n_outside = 0, n_full = 0;
	int n_settings = 1, n_mismatch = 0;

	function automatic logic [17:0] bin_index(input logic [16:0] offs, input logic [23:0] scale,
			input logic fine);
		logic [40:0] prod;
		prod = offs * scale;
		if (fine) begin
			return 18'(prod[40:24]) + 18'd1;
		end
		return {1'b0, prod[40:25], 1'b1};
	endfunction

	function automatic logic [15:0] cell_centre(input logic [17:0] idx, input logic [19:0] width,
			input logic [15:0] offs, input logic fine);
		logic [39:0] twice;
		logic [39:0] prod;
		logic [39:0] rounded;
		longint q;
		twice = {21'd0, idx, 1'b0};
		prod = fine ? (twice - 40'd1) * width : twice * width;
		rounded = (prod + 40'd256) >> 9;
		q = longint'(rounded) - longint'(offs);
		if (q > 32767) begin
			return 16'h7FFF;
		end else if (q < -32768) begin
			return 16'h8000;
		end
		return q[15:0];
	endfunction

	function automatic cell_result_t bin_and_accumulate(input stim_t it);
		cell_result_t r;
		int eta_v, phi_v, aeta, phoff, k;
		logic fine;
		logic [17:0] ieta, iphi;
		logic [31:0] id_full;
		logic [24:0] sum;
		r = '0;
		if (it.mode) begin
			fill_count = 0;
			n_clears++;
			return r;
		end
		eta_v = it.eta;
		phi_v = it.phi;
		aeta = eta_v < 0 ? -eta_v : eta_v;
		if (aeta > int'(cfg_m.eta_max)) begin
			r.dropped = DROP_OUTSIDE;
			n_outside++;
			return r;
		end
		fine = aeta < int'(cfg_m.transition_eta);
		phoff = phi_v + int'(PI_Q12);
		if (phoff < 0) begin
			phoff = 0;
		end
		ieta = bin_index(17'(eta_v + int'(cfg_m.eta_max)), cfg_m.eta_scale, fine);
		iphi = bin_index(17'(phoff), cfg_m.phi_scale, fine);
		id_full = 32'(cfg_m.cells_in_phi) * 32'(ieta) + 32'(iphi);
		r.cell_id = id_full[23:0];
		for (k = 0; k < fill_count; k++) begin
			if (store_id[k] == r.cell_id) begin
				sum = store_pt[k] + it.pt;
				store_pt[k] = (sum > 25'(PT_MAX)) ? PT_MAX : sum[23:0];
				if (store_hits[k] != HITS_MAX) begin
					store_hits[k]++;
				end
				r.slot = k[7:0];
				r.pt_sum = store_pt[k];
				r.hits = store_hits[k];
				r.ceta = store_ceta[k];
				r.cphi = store_cphi[k];
				n_hits++;
				return r;
			end
		end
		r.ceta = cell_centre(ieta, cfg_m.eta_width, {1'b0, cfg_m.eta_max}, fine);
		r.cphi = cell_centre(iphi, cfg_m.phi_width, PI_Q12, fine);
		if (fill_count >= STORE_DEPTH) begin
			r.dropped = DROP_FULL;
			n_full++;
			return r;
		end
		k = fill_count;
		store_id[k] = r.cell_id;
		store_pt[k] = 24'(it.pt);
		store_hits[k] = 16'd1;
		store_ceta[k] = r.ceta;
		store_cphi[k] = r.cphi;
		fill_count++;
		r.slot = k[7:0];
		r.new_cell = 1'b1;
		r.pt_sum = 24'(it.pt);
		r.hits = 16'd1;
		n_new++;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (got !== want) begin
			n_mismatch++;
			if (n_mismatch <= REPORT_CAP) begin
				$display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
			end else if (n_mismatch == REPORT_CAP + 1) begin
				$display("%0t ns: further mismatch reports suppressed", $time);
			end
		end
	endtask

	task automatic queue_deposit(input logic md, input logic [19:0] pt, input int eta,
			input int phi, input int gap);
		stim_t s;
		s = '{default: '0};
		s.mode = md;
		s.pt = pt;
		s.eta = 16'(eta);
		s.phi = 16'(phi);
		s.gap = gap;
		pending.insert(pending.size(), s);
	endtask

	task automatic queue_setting(input binning_cfg_t c);
		stim_t s;
		logic [23:0] vals[8];
		int k;
		vals[REG_ETA_MAX] = {9'($urandom_range(511)), c.eta_max};
		vals[REG_TRANSITION_ETA] = {9'($urandom_range(511)), c.transition_eta};
		vals[REG_CELLS_IN_ETA] = {12'($urandom_range(4095)), c.cells_in_eta};
		vals[REG_CELLS_IN_PHI] = {12'($urandom_range(4095)), c.cells_in_phi};
		vals[REG_ETA_SCALE] = c.eta_scale;
		vals[REG_PHI_SCALE] = c.phi_scale;
		vals[REG_ETA_WIDTH] = {4'($urandom_range(15)), c.eta_width};
		vals[REG_PHI_WIDTH] = {4'($urandom_range(15)), c.phi_width};
		for (k = 0; k < 8; k++) begin
			s = '{default: '0};
			s.is_reg = 1'b1;
			s.reg_idx = k[2:0];
			s.reg_val = vals[k];
			pending.insert(pending.size(), s);
		end
		n_settings++;
	endtask

	function automatic logic [19:0] random_pt();
		int sel;
		sel = $urandom_range(99);
		if (sel < 50) begin
			return 20'($urandom);
		end else if (sel < 85) begin
			return 20'($urandom_range(1000));
		end else if (sel < 95) begin
			return DEPOSIT_PT_MAX;
		end
		return 20'd0;
	endfunction

	task automatic random_phase(input int budget, input int eta_lim);
		int left, pool_n, ev_len, gap_max, k, pick;
		int pool_eta[40];
		int pool_phi[40];
		left = budget;
		while (left > 0) begin
			gap_max = ($urandom_range(3) == 0) ? 0 : 10;
			if ($urandom_range(7) != 0) begin
				queue_deposit(1'b1, 20'($urandom), $urandom, $urandom, $urandom_range(gap_max));
				left--;
			end
			pool_n = $urandom_range(1, 40);
			for (k = 0; k < pool_n; k++) begin
				pool_eta[k] = int'($urandom_range(2 * eta_lim)) - eta_lim;
				pool_phi[k] = ($urandom_range(4) == 0) ? int'($urandom_range(65535)) - 32768
					: int'($urandom_range(25736)) - 12868;
			end
			ev_len = $urandom_range(1, 60);
			for (k = 0; k < ev_len && left > 0; k++) begin
				if ($urandom_range(99) < 85) begin
					pick = $urandom_range(pool_n - 1);
					queue_deposit(1'b0, random_pt(), pool_eta[pick], pool_phi[pick],
						$urandom_range(gap_max));
				end else begin
					queue_deposit($urandom_range(19) == 0, 20'($urandom), $urandom, $urandom,
						$urandom_range(gap_max));
				end
				left--;
			end
		end
	endtask

	function automatic binning_cfg_t physical_cfg();
		binning_cfg_t c;
		longint em, ce, cp, v;
		em = $urandom_range(4096, 32767);
		ce = $urandom_range(1, 4095);
		cp = $urandom_range(1, 4095);
		c.eta_max = 15'(em);
		c.transition_eta = 15'($urandom_range(32'(em)));
		c.cells_in_eta = 12'(ce);
		c.cells_in_phi = 12'(cp);
		c.eta_scale = 24'(ce * 64'd16777216 / (2 * em));
		c.phi_scale = 24'(cp * 64'd16777216 / 25736);
		v = 2 * em * 256 / ce;
		c.eta_width = (v > 1048575) ? 20'hFFFFF : 20'(v);
		c.phi_width = 20'(25736 * 256 / cp);
		return c;
	endfunction

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin : driver
		logic go;
		logic we_n;
		stim_t nxt;
		static stim_t cur = '{default: '0};
		static int wait_cnt = 0;
		static int quiet_cnt = 0;
		go = start;
		we_n = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				expected_cells.insert(expected_cells.size(), bin_and_accumulate(cur));
				n_transfers++;
				go = 1'b0;
				wait_cnt = cur.gap;
			end
			if (expected_cells.size() == 0 && !busy && !go) begin
				quiet_cnt++;
			end else begin
				quiet_cnt = 0;
			end
			if (!go && pending.size() > 0) begin
				if (pending[0].is_reg) begin
					if (quiet_cnt >= 3) begin
						nxt = pending.pop_front();
						case (nxt.reg_idx)
							REG_ETA_MAX: cfg_m.eta_max = nxt.reg_val[14:0];
							REG_TRANSITION_ETA: cfg_m.transition_eta = nxt.reg_val[14:0];
							REG_CELLS_IN_ETA: cfg_m.cells_in_eta = nxt.reg_val[11:0];
							REG_CELLS_IN_PHI: cfg_m.cells_in_phi = nxt.reg_val[11:0];
							REG_ETA_SCALE: cfg_m.eta_scale = nxt.reg_val;
							REG_PHI_SCALE: cfg_m.phi_scale = nxt.reg_val;
							REG_ETA_WIDTH: cfg_m.eta_width = nxt.reg_val[19:0];
							default: cfg_m.phi_width = nxt.reg_val[19:0];
						endcase
						we_n = 1'b1;
						cfg_index <= nxt.reg_idx;
						cfg_data <= nxt.reg_val;
					end
				end else if (wait_cnt > 0) begin
					wait_cnt--;
				end else begin
					cur = pending.pop_front();
					go = 1'b1;
					mode <= cur.mode;
					deposit_pt <= cur.pt;
					deposit_eta <= cur.eta;
					deposit_phi <= cur.phi;
				end
			end
		end
		start <= go;
		cfg_we <= we_n;
	end

	always @(posedge clk) begin : monitor
		cell_result_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_cells.size() == 0) begin
				check_field("unexpected result, cell_id", 24'hx, cell_id);
			end else begin
				want = expected_cells.pop_front();
				check_field("cell_id", want.cell_id, cell_id);
				check_field("slot", 24'(want.slot), 24'(slot));
				check_field("new_cell", 24'(want.new_cell), 24'(new_cell));
				check_field("cell_pt_sum", want.pt_sum, cell_pt_sum);
				check_field("cell_hit_count", 24'(want.hits), 24'(cell_hit_count));
				check_field("centre_eta", 24'(want.ceta), {8'd0, centre_eta});
				check_field("centre_phi", 24'(want.cphi), {8'd0, centre_phi});
				check_field("dropped", 24'(want.dropped), 24'(dropped));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		static int stall_cycles = 0;
		if (!arst_n || (start && !busy) || done === 1'b1) begin
			stall_cycles = 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end else begin
			stall_cycles++;
		end
	end

	initial begin : stimulus
		binning_cfg_t c;
		int k;

		// Directed: extremes, both granularities, phi clamping and pt saturation.
		queue_deposit(1'b1, DEPOSIT_PT_MAX, -1, -1, 0);
		queue_deposit(1'b0, 20'd100, 0, 0, $urandom_range(10));
		for (k = 0; k < 16; k++) begin
			queue_deposit(1'b0, DEPOSIT_PT_MAX, 0, 0, $urandom_range(10));
		end
		queue_deposit(1'b0, 20'd5, 15000, -12868, 0);
		queue_deposit(1'b0, 20'd7, -20480, -32768, 3);
		queue_deposit(1'b0, 20'd9, 20480, 32767, 10);
		queue_deposit(1'b0, 20'd1, 20481, 0, 0);
		queue_deposit(1'b0, 20'd1, -32768, 0, 1);
		queue_deposit(1'b0, 20'd1, 32767, 0, 2);
		queue_deposit(1'b0, 20'd3, 13107, 12867, 0);
		queue_deposit(1'b0, 20'd0, 13106, -1, 0);

		// Fill the store, then miss on a full store and hit an existing entry.
		queue_deposit(1'b1, 20'd0, 0, 0, 0);
		for (k = 0; k < STORE_DEPTH; k++) begin
			queue_deposit(1'b0, random_pt(), 0, -12868 + 100 * k, $urandom_range(10));
		end
		for (k = 0; k < 3; k++) begin
			queue_deposit(1'b0, random_pt(), 5000 + 700 * k, 1000, $urandom_range(10));
		end
		queue_deposit(1'b0, 20'd11, 0, -12868, 0);

		// Back-to-back deposits on one cell.
		queue_deposit(1'b1, 20'd0, 0, 0, 0);
		for (k = 0; k < 40; k++) begin
			queue_deposit(1'b0, 20'($urandom_range(255)), -3000, 2000, 0);
		end

		random_phase(150, int'(DEFAULT_CFG.eta_max));

		c = '{15'd0, 15'd0, 12'd1, 12'd1, 24'd0, 24'd0, 20'd0, 20'd0};
		queue_setting(c);
		random_phase(80, 0);

		c = '{15'h7FFF, 15'h7FFF, 12'hFFF, 12'hFFF, 24'hFFFFFF, 24'hFFFFFF, 20'hFFFFF, 20'hFFFFF};
		queue_setting(c);
		random_phase(150, 32767);

		for (k = 0; k < 3; k++) begin
			c = binning_cfg_t'(142'({$urandom, $urandom, $urandom, $urandom, $urandom}));
			if (c.cells_in_eta == 0) c.cells_in_eta = 12'd1;
			if (c.cells_in_phi == 0) c.cells_in_phi = 12'd1;
			queue_setting(c);
			random_phase(130, int'(c.eta_max));
		end

		for (k = 0; k < 2; k++) begin
			c = physical_cfg();
			queue_setting(c);
			random_phase(125, int'(c.eta_max));
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || start || expected_cells.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d transfers (%0d clears) under %0d register settings.",
			n_transfers, n_clears, n_settings);
		$display("Deposits: %0d new cells, %0d hits, %0d outside acceptance, %0d store full.",
			n_new, n_hits, n_outside, n_full);
		if (n_mismatch == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", n_mismatch);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
